FILE: sv/dwhs_pkg.sv
// Shared constants, types and the sine table of the wave height pipeline.
// Used by every module of the block; depends on nothing else.
package dwhs_pkg;

	localparam int NUM_WAVES = 4;
	localparam int TAB_BITS = 10;
	localparam int TAB_SIZE = 1 << TAB_BITS;
	localparam int QUARTER = TAB_SIZE >> 2;
	localparam int FRAC_BITS = 32 - TAB_BITS;
	localparam int LATENCY = 13;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SPATIAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPORAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 3'd4;

	localparam logic [31:0] SPATIAL_RESET = 32'd53687091;
	localparam logic [31:0] TEMPORAL_RESET = 32'd75000866;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	// Per-wave scale factors: 1/r in Q4.28, 1/sqrt(r) in Q2.30, r in Q1.31.
	localparam logic [31:0] SPACE_SCALE [NUM_WAVES] =
		'{32'd268435456, 32'd506481992, 32'd925639503, 32'd1579032094};
	localparam logic [31:0] TIME_SCALE [NUM_WAVES] =
		'{32'd1073741824, 32'd1474897824, 32'd1993888512, 32'd2604206444};
	localparam logic [31:0] AMP_SCALE [NUM_WAVES] =
		'{32'd2147483648, 32'd1138166333, 32'd622770258, 32'd365072220};
	localparam logic [31:0] PHASE_OFFSET [NUM_WAVES] =
		'{32'd0, 32'd1162060969, 32'd2324121938, 32'd3486182907};
	// Heading step multipliers 2i-3, modulo 2^17.
	localparam logic [16:0] HEAD_MUL [NUM_WAVES] =
		'{17'h1FFFD, 17'h1FFFF, 17'd1, 17'd3};

	// Per-wave coefficients derived from the configuration registers.
	typedef struct packed {
		logic [35:0]        k;
		logic [45:0]        f;
		logic [31:0]        a;
		logic signed [31:0] dx;
		logic signed [31:0] dz;
		logic [31:0]        offset;
	} coef_t;

	typedef logic signed [31:0] sine_tab_t [TAB_SIZE];

	// Quarter-wave sample in Q30 from a Taylor series through x^11.
	function automatic logic signed [31:0] quarter_sine(input int unsigned m);
		logic [63:0] x;
		logic [63:0] term;
		logic signed [63:0] sum;
		if (m >= QUARTER) begin
			return 32'(ONE_Q30);
		end
		x = (64'(m) * HALF_PI_Q30) >> (TAB_BITS - 2);
		term = x;
		sum = signed'(x);
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd6;
		sum = sum - signed'(term);
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd20;
		sum = sum + signed'(term);
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd42;
		sum = sum - signed'(term);
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd72;
		sum = sum + signed'(term);
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd110;
		sum = sum - signed'(term);
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		if (sum < 0) begin
			sum = 0;
		end
		return 32'(sum);
	endfunction

	// Full-turn table built from the quarter wave by symmetry.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		int unsigned q;
		int unsigned r;
		logic signed [31:0] v;
		for (int unsigned j = 0; j < TAB_SIZE; j++) begin
			q = j >> (TAB_BITS - 2);
			r = j & (QUARTER - 1);
			v = q[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
			tab[j] = q[1] ? -v : v;
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/directional_wave_height_sum.sv
// A result strobes on done after the capture, lane, sum and saturate registers.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// After a configuration write, coefficients settle via registers and sine lookups.
// Reset: arst_n clears the configuration to its defaults and empties the pipeline.
// The receiver cannot stall: each result stays on surface_height until the next.
module directional_wave_height_sum import dwhs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_z,
	input  logic [31:0]          time_s,
	output logic                 done,
	output logic signed [31:0]   surface_height,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata
);

	localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
	localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

	coef_t              coef [NUM_WAVES];
	logic [LATENCY-1:0] vld_q;
	logic               accept;
	logic signed [31:0] px_s1, pz_s1;
	logic [31:0]        t_s1;
	logic signed [34:0] term [NUM_WAVES];
	logic signed [36:0] total;
	logic signed [36:0] sum_s12;
	logic signed [31:0] height_s13;

	assign busy = 1'b0;
	assign accept = start && !busy;

	dwhs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	// Valid bits travel alongside the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], accept};
		end
	end

	// Input item capture.
	always_ff @(posedge clk) begin
		px_s1 <= pos_x;
		pz_s1 <= pos_z;
		t_s1 <= time_s;
	end

	for (genvar i = 0; i < NUM_WAVES; i++) begin : g_lane
		dwhs_lane u_lane (
			.clk  (clk),
			.coef (coef[i]),
			.px   (px_s1),
			.pz   (pz_s1),
			.t    (t_s1),
			.term (term[i])
		);
	end

	// Exact sum of the wave terms.
	always_comb begin
		total = '0;
		for (int i = 0; i < NUM_WAVES; i++) begin
			total = total + 37'(term[i]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s12 <= total;
	end

	// Saturate to the output range; the register holds between results.
	always_ff @(posedge clk) begin
		if (vld_q[LATENCY-2]) begin
			if (sum_s12 > SAT_MAX) begin
				height_s13 <= 32'sh7FFF_FFFF;
			end else if (sum_s12 < SAT_MIN) begin
				height_s13 <= 32'sh8000_0000;
			end else begin
				height_s13 <= sum_s12[31:0];
			end
		end
	end

	assign done = vld_q[LATENCY-1];
	assign surface_height = height_s13;

endmodule

FILE: sv/dwhs_sine.sv
// Three-stage interpolated sine lookup over a full turn of phase.
// Depends on dwhs_pkg for the table and its geometry.
module dwhs_sine import dwhs_pkg::*; (
	input  logic               clk,
	input  logic [31:0]        phase,
	output logic signed [31:0] sine
);

	localparam int PW = 34 + FRAC_BITS;

	logic [TAB_BITS-1:0]  idx;
	logic [TAB_BITS-1:0]  idx_n;
	logic [FRAC_BITS-1:0] frac_q;
	logic signed [31:0]   s0_q;
	logic signed [31:0]   s1_q;
	logic signed [32:0]   diff;
	logic signed [31:0]   base_q;
	logic signed [PW-1:0] prod_q;

	// Table addresses of the two neighboring samples.
	always_comb begin
		idx = phase[31:FRAC_BITS];
		idx_n = idx + TAB_BITS'(1);
	end

	// Registered table reads.
	always_ff @(posedge clk) begin
		s0_q <= SINE_TAB[idx];
		s1_q <= SINE_TAB[idx_n];
		frac_q <= phase[FRAC_BITS-1:0];
	end

	// Slope product between the samples.
	assign diff = 33'(s1_q) - 33'(s0_q);

	always_ff @(posedge clk) begin
		base_q <= s0_q;
		prod_q <= PW'(diff) * PW'(signed'({1'b0, frac_q}));
	end

	// Floored correction added to the lower sample.
	always_ff @(posedge clk) begin
		sine <= base_q + prod_q[FRAC_BITS+31:FRAC_BITS];
	end

endmodule

FILE: sv/dwhs_cfg.sv
// Configuration registers and the per-wave coefficients derived from them.
// Depends on dwhs_pkg and dwhs_sine; coefficients follow a write through registers.
module dwhs_cfg import dwhs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata,
	output coef_t                coef [NUM_WAVES]
);

	logic [31:0] spatial_q;
	logic [31:0] temporal_q;
	logic [31:0] amplitude_q;
	logic [15:0] wind_q;
	logic [15:0] spread_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spatial_q <= SPATIAL_RESET;
			temporal_q <= TEMPORAL_RESET;
			amplitude_q <= '0;
			wind_q <= '0;
			spread_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SPATIAL: spatial_q <= cfg_wdata;
				REG_TEMPORAL: temporal_q <= cfg_wdata;
				REG_AMPLITUDE: amplitude_q <= cfg_wdata;
				REG_WIND: wind_q <= cfg_wdata[15:0];
				REG_SPREAD: spread_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < NUM_WAVES; i++) begin : g_wave
		logic [63:0] kprod;
		logic [63:0] fprod;
		logic [63:0] aprod;
		logic [16:0] hmul;
		logic [35:0] k_q;
		logic [45:0] f_q;
		logic [31:0] a_q;
		logic [16:0] head_q;
		logic signed [31:0] dx;
		logic signed [31:0] dz;

		// Scaled frequencies, amplitude and heading of this wave.
		always_comb begin
			kprod = 64'(spatial_q) * 64'(SPACE_SCALE[i]);
			fprod = 64'(temporal_q) * 64'(TIME_SCALE[i]);
			aprod = 64'(amplitude_q) * 64'(AMP_SCALE[i]);
			hmul = 17'({1'b0, spread_q} * HEAD_MUL[i]);
		end

		always_ff @(posedge clk) begin
			k_q <= kprod[63:28];
			f_q <= fprod[63:18];
			a_q <= aprod[62:31];
			head_q <= {wind_q, 1'b0} + hmul;
		end

		// Direction cosine and sine of the heading.
		dwhs_sine u_cos (
			.clk   (clk),
			.phase ({head_q, 15'b0} + QUARTER_TURN),
			.sine  (dx)
		);

		dwhs_sine u_sin (
			.clk   (clk),
			.phase ({head_q, 15'b0}),
			.sine  (dz)
		);

		assign coef[i] = '{k: k_q, f: f_q, a: a_q, dx: dx, dz: dz,
			offset: PHASE_OFFSET[i]};
	end

endmodule

FILE: sv/dwhs_lane.sv
// Pipeline lane for one wave: phase from position and time, sine, amplitude.
// Depends on dwhs_pkg and dwhs_sine; the term leaves the amplitude register.
module dwhs_lane import dwhs_pkg::*; (
	input  logic               clk,
	input  coef_t              coef,
	input  logic signed [31:0] px,
	input  logic signed [31:0] pz,
	input  logic [31:0]        t,
	output logic signed [34:0] term
);

	logic [55:0]        tp_lo_s2;
	logic [27:0]        tp_hi_s2;
	logic signed [31:0] px_s2, pz_s2, px_s3, pz_s3;
	logic [55:0]        tsum;
	logic [31:0]        ph_time_s3, ph_time_s4, ph_time_s5, ph_time_s6;
	logic signed [63:0] prx_s4, prz_s4;
	logic signed [64:0] dsum;
	logic signed [40:0] d_s5;
	logic [51:0]        d52;
	logic [51:0]        pp0_s6;
	logic [25:0]        pp1_s6, pp2_s6;
	logic [51:0]        ssum;
	logic [31:0]        phase_s7;
	logic signed [31:0] sin_s10;
	logic signed [64:0] prod_s11;

	// Time products, the frequency split in two partial products.
	always_ff @(posedge clk) begin
		tp_lo_s2 <= 56'(60'(coef.f[27:0]) * 60'(t));
		tp_hi_s2 <= 28'(50'(coef.f[45:28]) * 50'(t));
		px_s2 <= px;
		pz_s2 <= pz;
	end

	// Time phase is bits 24..55 of the product.
	assign tsum = tp_lo_s2 + {tp_hi_s2, 28'b0};

	always_ff @(posedge clk) begin
		ph_time_s3 <= tsum[55:24];
		px_s3 <= px_s2;
		pz_s3 <= pz_s2;
	end

	// Projection of the position onto the wave heading.
	always_ff @(posedge clk) begin
		prx_s4 <= 64'(coef.dx) * 64'(px_s3);
		prz_s4 <= 64'(coef.dz) * 64'(pz_s3);
		ph_time_s4 <= ph_time_s3;
	end

	assign dsum = 65'(prx_s4) + 65'(prz_s4);

	always_ff @(posedge clk) begin
		d_s5 <= dsum[64:24];
		ph_time_s5 <= ph_time_s4;
	end

	// Spatial product modulo 2^52 from three partial products.
	assign d52 = 52'(d_s5);

	always_ff @(posedge clk) begin
		pp0_s6 <= 52'(coef.k[25:0]) * 52'(d52[25:0]);
		pp1_s6 <= 26'(52'(coef.k[25:0]) * 52'(d52[51:26]));
		pp2_s6 <= 26'(36'(coef.k[35:26]) * 36'(d52[25:0]));
		ph_time_s6 <= ph_time_s5;
	end

	assign ssum = pp0_s6 + {pp1_s6 + pp2_s6, 26'b0};

	// Wave phase in turns, wrapping.
	always_ff @(posedge clk) begin
		phase_s7 <= ssum[51:20] - ph_time_s6 + coef.offset;
	end

	dwhs_sine u_sine (
		.clk   (clk),
		.phase (phase_s7),
		.sine  (sin_s10)
	);

	// Amplitude scaling; the term is the product floored to Q24.
	always_ff @(posedge clk) begin
		prod_s11 <= 65'(signed'({1'b0, coef.a})) * 65'(sin_s10);
	end

	assign term = prod_s11[64:30];

endmodule

FILE: sv/dwhs_checker.sv
// Port-level checks of the wave height block, attached by bind.
// Depends on dwhs_pkg for the pipeline latency.
module dwhs_checker import dwhs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// Every accepted item yields a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item produced no result");

	// No result without an item accepted the fixed latency before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching item");

	// The pipeline never refuses an item.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy asserted");

endmodule

bind directional_wave_height_sum dwhs_checker u_dwhs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
